// ===== rtl/md5_pin_candidate_matcher_assert.svh =====
// assertion macros used by the md5 pin matcher port checker
`ifndef MD5_PIN_CANDIDATE_MATCHER_ASSERT_SVH
`define MD5_PIN_CANDIDATE_MATCHER_ASSERT_SVH

// property checked on every clock edge outside reset
`define MPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define MPCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpcm_pkg.sv =====
// shared types, constants and md5 helper functions for the pin matcher
package mpcm_pkg;

	// field widths
	localparam int CAND_W     = 14;
	localparam int BCD_DIGS   = 5;
	localparam int BCD_W      = BCD_DIGS * 4;
	localparam int DD_HALF    = CAND_W / 2;
	localparam int MAX_DIGITS = 8;
	localparam int DIGVEC_W   = MAX_DIGITS * 4;
	localparam int DIGITS_DEF = 4;
	localparam int TDATA_W    = 16;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int ROUNDS     = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LO = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HI = 1'b1;

	// md5 initial state
	localparam logic [31:0] MD5_IV_A = 32'h67452301;
	localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
	localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
	localparam logic [31:0] MD5_IV_D = 32'h10325476;

	// round constants
	localparam logic [31:0] MD5_K [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts
	localparam int MD5_ROT [ROUNDS] = '{
		7, 12, 17, 22, 7, 12, 17, 22, 7, 12, 17, 22, 7, 12, 17, 22,
		5, 9, 14, 20, 5, 9, 14, 20, 5, 9, 14, 20, 5, 9, 14, 20,
		4, 11, 16, 23, 4, 11, 16, 23, 4, 11, 16, 23, 4, 11, 16, 23,
		6, 10, 15, 21, 6, 10, 15, 21, 6, 10, 15, 21, 6, 10, 15, 21
	};

	// valid bit and candidate that travel down the pipeline
	typedef struct packed {
		logic              valid;
		logic [CAND_W-1:0] cand;
	} mpcm_tag_t;

	// working state of one round, tp holds a + k + m for the coming round
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] tp;
	} md5_st_t;

	// message word index used by a round
	function automatic int md5_g(input int r);
		int g;
		if (r < 16) begin
			g = r;
		end else if (r < 32) begin
			g = (5 * r + 1) & 15;
		end else if (r < 48) begin
			g = (3 * r + 5) & 15;
		end else begin
			g = (7 * r) & 15;
		end
		return g;
	endfunction

	// rotate left by a constant amount of 1..31
	function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	// one double-dabble step: adjust the digits, then shift in the next bit
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic bin);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int k = 0; k < BCD_DIGS; k++) begin
			if (adj[4*k +: 4] >= 4'd5) begin
				adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bin};
	endfunction

	// word w of the single padded block holding nd ascii digits
	function automatic logic [31:0] msg_word(input logic [DIGVEC_W-1:0] chars, input int nd,
			input int w);
		logic [31:0] word;
		int idx;
		word = '0;
		for (int k = 0; k < 4; k++) begin
			idx = 4 * w + k;
			if (idx < nd) begin
				word[8*k +: 8] = {4'h3, chars[4*idx[2:0] +: 4]};
			end else if (idx == nd) begin
				word[8*k +: 8] = 8'h80;
			end else if (idx == 56) begin
				word[8*k +: 8] = 8'(nd * 8);
			end
		end
		return word;
	endfunction

endpackage

// ===== rtl/mpcm_digits.sv =====
// binary to decimal conversion and first message word of the md5 block
module mpcm_digits #(
	parameter int DIGITS = mpcm_pkg::DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  mpcm_pkg::mpcm_tag_t   up_tag,
	output mpcm_pkg::mpcm_tag_t   dn_tag,
	output mpcm_pkg::md5_st_t     dn_st,
	output logic [DIGITS*4-1:0]   dn_dig
);
	import mpcm_pkg::*;

	localparam int DW = DIGITS * 4;

	mpcm_tag_t        tag_s1, tag_s2, tag_s3;
	logic [BCD_W-1:0] bcd_s1, bcd_s2;
	md5_st_t          st_s3;
	logic [DW-1:0]    dig_s3;
	logic [BCD_W-1:0] bcd_hi, bcd_lo;
	logic [DW-1:0]    chars;
	logic [31:0]      word0;

	// upper half of the candidate bits
	always_comb begin
		bcd_hi = '0;
		for (int i = 0; i < DD_HALF; i++) begin
			bcd_hi = dd_step(bcd_hi, up_tag.cand[CAND_W-1-i]);
		end
	end

	// lower half of the candidate bits
	always_comb begin
		bcd_lo = bcd_s1;
		for (int i = 0; i < CAND_W - DD_HALF; i++) begin
			bcd_lo = dd_step(bcd_lo, tag_s1.cand[CAND_W-DD_HALF-1-i]);
		end
	end

	// leading DIGITS characters of the decimal string, zero padded
	always_comb begin
		int nd;
		int total;
		int p;
		nd = 1;
		for (int q = 0; q < BCD_DIGS; q++) begin
			if (bcd_s2[4*q +: 4] != 4'd0) begin
				nd = q + 1;
			end
		end
		total = (nd > DIGITS) ? nd : DIGITS;
		chars = '0;
		for (int j = 0; j < DIGITS; j++) begin
			p = total - 1 - j;
			for (int q = 0; q < BCD_DIGS; q++) begin
				if (q == p) begin
					chars[4*j +: 4] = bcd_s2[4*q +: 4];
				end
			end
		end
	end

	assign word0 = msg_word(DIGVEC_W'(chars), DIGITS, md5_g(0));

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (advance) begin
			tag_s1 <= up_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			bcd_s1   <= bcd_hi;
			bcd_s2   <= bcd_lo;
			dig_s3   <= chars;
			st_s3.a  <= MD5_IV_A;
			st_s3.b  <= MD5_IV_B;
			st_s3.c  <= MD5_IV_C;
			st_s3.d  <= MD5_IV_D;
			st_s3.tp <= MD5_IV_A + MD5_K[0] + word0;
		end
	end

	assign dn_tag = tag_s3;
	assign dn_st  = st_s3;
	assign dn_dig = dig_s3;

endmodule

// ===== rtl/mpcm_round.sv =====
// one md5 round as one pipeline stage
module mpcm_round #(
	parameter int DIGITS = mpcm_pkg::DIGITS_DEF,
	parameter int RND    = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  mpcm_pkg::mpcm_tag_t up_tag,
	input  mpcm_pkg::md5_st_t   up_st,
	input  logic [DIGITS*4-1:0] up_dig,
	output mpcm_pkg::mpcm_tag_t dn_tag,
	output mpcm_pkg::md5_st_t   dn_st,
	output logic [DIGITS*4-1:0] dn_dig
);
	import mpcm_pkg::*;

	localparam int DW  = DIGITS * 4;
	localparam int GRP = RND / 16;
	localparam int NXT = (RND + 1) % ROUNDS;

	mpcm_tag_t     tag_s1;
	md5_st_t       st_s1;
	logic [DW-1:0] dig_s1;
	logic [31:0]   fun, sum, b_new, tp_new;

	// round function of this group
	always_comb begin
		case (GRP)
			0:       fun = (up_st.b & up_st.c) | (~up_st.b & up_st.d);
			1:       fun = (up_st.d & up_st.b) | (~up_st.d & up_st.c);
			2:       fun = up_st.b ^ up_st.c ^ up_st.d;
			default: fun = up_st.c ^ (up_st.b | ~up_st.d);
		endcase
	end

	// new b, and a + k + m precomputed for the next round (next a is d)
	assign sum    = fun + up_st.tp;
	assign b_new  = up_st.b + rotl32(sum, MD5_ROT[RND]);
	assign tp_new = up_st.d + MD5_K[NXT] + msg_word(DIGVEC_W'(up_dig), DIGITS, md5_g(NXT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (advance) begin
			tag_s1 <= up_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1.a  <= up_st.d;
			st_s1.b  <= b_new;
			st_s1.c  <= up_st.b;
			st_s1.d  <= up_st.c;
			st_s1.tp <= tp_new;
			dig_s1   <= up_dig;
		end
	end

	assign dn_tag = tag_s1;
	assign dn_st  = st_s1;
	assign dn_dig = dig_s1;

endmodule

// ===== rtl/mpcm_tail.sv =====
// digest finish, target compare and output skid buffer
module mpcm_tail (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mpcm_pkg::mpcm_tag_t            up_tag,
	input  mpcm_pkg::md5_st_t              up_st,
	input  logic [mpcm_pkg::CFG_W-1:0]     target_lo,
	input  logic [mpcm_pkg::CFG_W-1:0]     target_hi,
	output logic                           advance,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mpcm_pkg::TDATA_W-1:0]   m_axis_tdata
);
	import mpcm_pkg::*;

	mpcm_tag_t          tag_s1, tag_s2;
	logic [31:0]        h0_s1, h1_s1, h2_s1, h3_s1;
	logic               match_s2;
	logic               out_vld_q, spr_vld_q;
	logic [TDATA_W-1:0] out_dat_q, spr_dat_q;
	logic [TDATA_W-1:0] push_dat;
	logic               push, out_free;

	// pipeline moves while the spare slot is empty
	assign advance  = !spr_vld_q;
	assign push     = advance && tag_s2.valid;
	assign out_free = !out_vld_q || m_axis_tready;
	assign push_dat = {1'b0, match_s2, tag_s2.cand};

	// final add then compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (advance) begin
			tag_s1 <= up_tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			h0_s1    <= MD5_IV_A + up_st.a;
			h1_s1    <= MD5_IV_B + up_st.b;
			h2_s1    <= MD5_IV_C + up_st.c;
			h3_s1    <= MD5_IV_D + up_st.d;
			match_s2 <= ({h1_s1, h0_s1} == target_lo) && ({h3_s1, h2_s1} == target_hi);
		end
	end

	// output register with one spare slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			spr_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= spr_vld_q || push;
			spr_vld_q <= 1'b0;
		end else if (push) begin
			spr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_dat_q <= spr_vld_q ? spr_dat_q : push_dat;
		end else if (push) begin
			spr_dat_q <= push_dat;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_dat_q;

endmodule

// ===== rtl/md5_pin_candidate_matcher.sv =====
// top level: pipelined md5 pin candidate matcher
//
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata[13:0] candidate
// m_axis    out  tvalid/tready    tdata[13:0] candidate_echo, [14] match
// cfg       in   cfg_wen          cfg_addr 0 target low, 1 target high, cfg_wdata
//
// one candidate accepted per cycle while the spare slot is empty; 70 pipeline stages (input, 3 decimal
// conversion, 64 md5 rounds, digest add, compare) then the output register.
// arst_n clears all valid bits and both target registers.
// a stalled output fills one spare slot, then the whole pipeline holds.
module md5_pin_candidate_matcher #(
	parameter int DIGITS = mpcm_pkg::DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mpcm_pkg::TDATA_W-1:0]     s_axis_tdata,  // [13:0] candidate, [15:14] zero
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mpcm_pkg::TDATA_W-1:0]     m_axis_tdata,  // [13:0] candidate_echo, [14] match
	input  logic                             cfg_wen,
	input  logic [mpcm_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [mpcm_pkg::CFG_W-1:0]       cfg_wdata
);
	import mpcm_pkg::*;

	localparam int DW = DIGITS * 4;

	logic             advance;
	logic [CFG_W-1:0] target_lo_q, target_hi_q;
	mpcm_tag_t        tag_s1;
	mpcm_tag_t        chain_tag [ROUNDS+1];
	md5_st_t          chain_st  [ROUNDS+1];
	logic [DW-1:0]    chain_dig [ROUNDS+1];

	// target digest registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_lo_q <= '0;
			target_hi_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				CFG_TARGET_LO: target_lo_q <= cfg_wdata;
				CFG_TARGET_HI: target_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (advance) begin
			tag_s1.valid <= s_axis_tvalid;
			tag_s1.cand  <= s_axis_tdata[CAND_W-1:0];
		end
	end

	// decimal string and first message word
	mpcm_digits #(
		.DIGITS (DIGITS)
	) u_digits (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.up_tag  (tag_s1),
		.dn_tag  (chain_tag[0]),
		.dn_st   (chain_st[0]),
		.dn_dig  (chain_dig[0])
	);

	// md5 rounds, one stage each
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		mpcm_round #(
			.DIGITS (DIGITS),
			.RND    (r)
		) u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.up_tag  (chain_tag[r]),
			.up_st   (chain_st[r]),
			.up_dig  (chain_dig[r]),
			.dn_tag  (chain_tag[r+1]),
			.dn_st   (chain_st[r+1]),
			.dn_dig  (chain_dig[r+1])
		);
	end

	// digest, compare and output
	mpcm_tail u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_tag        (chain_tag[ROUNDS]),
		.up_st         (chain_st[ROUNDS]),
		.target_lo     (target_lo_q),
		.target_hi     (target_hi_q),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== rtl/mpcm_checker.sv =====
// port-level checks for the md5 pin matcher, bound to the top level
`include "md5_pin_candidate_matcher_assert.svh"

module mpcm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [mpcm_pkg::TDATA_W-1:0]   m_axis_tdata
);

	// no result in the cycle after reset is seen low
	`MPCM_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |=> !m_axis_tvalid, "result valid during reset")

	// input stalls only behind a waiting result
	`MPCM_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result waiting")

	// a taken result frees the input side
	`MPCM_ASSERT(a_ready_back, m_axis_tvalid && m_axis_tready |=> s_axis_tready, "input still stalled after result taken")

	// a refused result holds
	`MPCM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind md5_pin_candidate_matcher mpcm_checker u_mpcm_checker (.*);

// ===== test/md5_pin_tb_pkg.sv =====
// digest model of the four-character pin string shared by the pin matcher testbench
`timescale 1ns / 100ps

package md5_pin_tb_pkg;

	// characters hashed per candidate, same as the block's default
	localparam int PIN_CHARS = mpcm_pkg::DIGITS_DEF;

	// md5 additive constants
	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, four per group of sixteen rounds
	localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	// digest of the zero-padded decimal string of a pin, word 0 in bits 31:0
	function automatic logic [127:0] pin_digest(input logic [mpcm_pkg::CAND_W-1:0] pin);
		logic [7:0] text [64];
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f;
		int dec [5];
		int v, nd, total, pos, g, s;
		v = pin;
		nd = 1;
		for (int p = 0; p < 5; p++) begin
			dec[p] = v % 10;
			v = v / 10;
			if (dec[p] != 0) nd = p + 1;
		end
		// wider values keep only their leading characters
		total = (nd > PIN_CHARS) ? nd : PIN_CHARS;
		for (int j = 0; j < 64; j++) text[j] = 8'h00;
		for (int j = 0; j < PIN_CHARS; j++) begin
			pos = total - 1 - j;
			text[j] = 8'h30 + 8'((pos < 5) ? dec[pos] : 0);
		end
		text[PIN_CHARS] = 8'h80;
		text[56] = 8'(PIN_CHARS * 8);
		for (int i = 0; i < 16; i++) begin
			w[i] = {text[4*i+3], text[4*i+2], text[4*i+1], text[4*i]};
		end
		a = 32'h67452301;
		b = 32'hefcdab89;
		c = 32'h98badcfe;
		d = 32'h10325476;
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			s = ROT_AMT[(i / 16) * 4 + i % 4];
			f = f + a + SINE_K[i] + w[g];
			a = d;
			d = c;
			c = b;
			b = b + ((f << s) | (f >> (32 - s)));
		end
		return {d + 32'h10325476, c + 32'h98badcfe, b + 32'hefcdab89, a + 32'h67452301};
	endfunction

endpackage

// ===== test/md5_pin_candidate_matcher_checker.sv =====
// checker that predicts and compares every pin matcher result
`timescale 1ns / 100ps

module md5_pin_candidate_matcher_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	input  logic [mpcm_pkg::TDATA_W-1:0]        s_axis_tdata,  // [13:0] candidate
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic [mpcm_pkg::TDATA_W-1:0]        m_axis_tdata,  // [13:0] candidate_echo, [14] match
	input  logic                                cfg_wen,
	input  logic [mpcm_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [mpcm_pkg::CFG_W-1:0]          cfg_wdata,
	output int                                  error_count,
	output int                                  pending
);
	import mpcm_pkg::*;
	import md5_pin_tb_pkg::*;

	typedef struct packed {
		logic [CAND_W-1:0] pin;
		logic              match;
	} pin_verdict_t;

	logic [CFG_W-1:0] target_lo;
	logic [CFG_W-1:0] target_hi;
	pin_verdict_t     verdict_q [$];

	// track target writes, predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin : scoreboard
		pin_verdict_t want;
		logic [CAND_W-1:0] got_pin;
		logic got_match;
		logic [127:0] dg;
		int n_bad;
		if (!arst_n) begin
			target_lo <= '0;
			target_hi <= '0;
			verdict_q.delete();
			error_count <= 0;
			pending <= 0;
		end else begin
			n_bad = 0;
			if (cfg_wen) begin
				case (cfg_addr)
					CFG_TARGET_LO: target_lo <= cfg_wdata;
					CFG_TARGET_HI: target_hi <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want.pin = s_axis_tdata[CAND_W-1:0];
				dg = pin_digest(want.pin);
				want.match = (dg[63:0] == target_lo) && (dg[127:64] == target_hi);
				verdict_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_pin = m_axis_tdata[CAND_W-1:0];
				got_match = m_axis_tdata[CAND_W];
				if (verdict_q.size() == 0) begin
					$error("unexpected result: candidate_echo %0d match %0b", got_pin, got_match);
					n_bad++;
				end else begin
					want = verdict_q.pop_front();
					if (got_pin !== want.pin) begin
						$error("candidate_echo: expected %0d, actual %0d", want.pin, got_pin);
						n_bad++;
					end
					if (got_match !== want.match) begin
						$error("match: expected %0b, actual %0b (candidate %0d)",
							want.match, got_match, want.pin);
						n_bad++;
					end
				end
			end
			error_count <= error_count + n_bad;
			pending <= verdict_q.size();
		end
	end

endmodule

// ===== test/tb_md5_pin_candidate_matcher.sv =====
// stimulus and verdict for the md5 pin candidate matcher
`timescale 1ns / 100ps

module tb_md5_pin_candidate_matcher;
	import mpcm_pkg::*;
	import md5_pin_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 212;
	localparam int LONG_STALL   = 400;
	localparam logic [CAND_W-1:0] EDGE_PINS [14] = '{
		14'd0, 14'd9999, 14'd1, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999,
		14'd1000, 14'd10000, 14'd12345, 14'd16383, 14'h2AAA, 14'h1555
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = CFG_TARGET_LO;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	int          error_count;
	int          pending;
	int unsigned sent_count = 0;
	int unsigned recv_count = 0;
	int unsigned cycle_count = 0;
	bit          tx_pace = 1'b0;
	bit          rx_pace = 1'b0;
	bit          long_stall_req = 1'b0;

	always #4 clk = ~clk;

	md5_pin_candidate_matcher #(
		.DIGITS(PIN_CHARS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	md5_pin_candidate_matcher_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.error_count(error_count),
		.pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// results taken by the sink
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) recv_count <= recv_count + 1;
	end

	// sink readiness: random stall bursts, plus one long hold-off on request
	initial begin : result_pacing
		int unsigned hold_left;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (hold_left = LONG_STALL; hold_left > 0; hold_left--) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (rx_pace && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// offer one candidate, with an optional gap first, and wait for acceptance
	task automatic send_pin(input logic [CAND_W-1:0] pin);
		if (tx_pace && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_W - CAND_W){1'b0}}, pin};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_count++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (recv_count != sent_count);
	endtask

	// write both target halves on consecutive edges
	task automatic load_target(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		cfg_wen <= 1'b1;
		cfg_addr <= CFG_TARGET_LO;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_addr <= CFG_TARGET_HI;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// twin with the goal's leading characters: goal*10+d, goal/10, else goal
	function automatic logic [CAND_W-1:0] prefix_twin(input logic [CAND_W-1:0] goal);
		int t;
		if (goal >= 1000 && goal <= 1638) begin
			t = goal * 10 + $urandom_range(0, 9);
			return (t > 16383) ? goal : CAND_W'(t);
		end else if (goal >= 10000) begin
			return goal / 10;
		end
		return goal;
	endfunction

	// random candidate biased toward the current goal and the field extremes
	function automatic logic [CAND_W-1:0] draw_pin(input logic [CAND_W-1:0] goal);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12) return goal;
		if (r < 18) return prefix_twin(goal);
		if (r < 65) return CAND_W'($urandom_range(0, 9999));
		if (r < 85) return CAND_W'($urandom_range(10000, 16383));
		if (r < 90) return CAND_W'($urandom_range(0, 16383));
		return EDGE_PINS[$urandom_range(0, 13)];
	endfunction

	initial begin : stimulus
		logic [127:0] dg;
		logic [CAND_W-1:0] goal;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes against the reset targets
		foreach (EDGE_PINS[i]) send_pin(EDGE_PINS[i]);
		drain();

		// exact target, wide values that share its leading characters, neighbors
		dg = pin_digest(14'd1234);
		load_target(dg[63:0], dg[127:64]);
		send_pin(14'd1234);
		send_pin(14'd12340);
		send_pin(14'd12349);
		send_pin(14'd1233);
		send_pin(14'd123);
		drain();

		// only one target half right
		load_target(dg[63:0], ~dg[127:64]);
		send_pin(14'd1234);
		drain();
		load_target(~dg[63:0], dg[127:64]);
		send_pin(14'd1234);
		drain();

		// all-ones and all-zeros targets
		load_target({CFG_W{1'b1}}, {CFG_W{1'b1}});
		send_pin(14'd16383);
		send_pin(14'd0);
		drain();
		load_target('0, '0);
		send_pin(14'd5);
		drain();

		// random phases, each with its own target
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 1) goal = CAND_W'($urandom_range(10000, 16383));
			else if (p == 5) goal = CAND_W'($urandom_range(1000, 1638));
			else goal = CAND_W'($urandom_range(0, 9999));
			dg = pin_digest(goal);
			if (p == 3) load_target({$urandom, $urandom}, {$urandom, $urandom});
			else load_target(dg[63:0], dg[127:64]);
			// the closing phase runs with no idling on either side
			tx_pace = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			rx_pace = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (p == 2) long_stall_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) send_pin(draw_pin(goal));
		end
		drain();
		repeat (100) @(posedge clk);

		if (error_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
